// ===== hw/rtl/usc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usc_pkg
// Types and constants shared by the user name syntax checker modules.
// ----------------------------------------------------------------------------
package usc_pkg;

   localparam int unsigned COUNT_W = 6;
   localparam logic [COUNT_W-1:0] COUNT_SAT = 6'd63;

   localparam logic [2:0] STATUS_OK      = 3'd0;
   localparam logic [2:0] STATUS_LENGTH  = 3'd1;
   localparam logic [2:0] STATUS_SYNTAX  = 3'd2;
   localparam logic [2:0] STATUS_FIRST   = 3'd3;
   localparam logic [2:0] STATUS_HEX     = 3'd4;
   localparam logic [2:0] STATUS_OCTAL   = 3'd5;
   localparam logic [2:0] STATUS_NUMERIC = 3'd6;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_DASH   = 8'h2d;
   localparam logic [7:0] CHAR_DOT    = 8'h2e;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_SEVEN  = 8'h37;
   localparam logic [7:0] CHAR_NINE   = 8'h39;
   localparam logic [7:0] CHAR_UNDER  = 8'h5f;
   localparam logic [7:0] CHAR_LOW_A  = 8'h61;
   localparam logic [7:0] CHAR_LOW_F  = 8'h66;
   localparam logic [7:0] CHAR_LOW_O  = 8'h6f;
   localparam logic [7:0] CHAR_LOW_X  = 8'h78;
   localparam logic [7:0] CHAR_LOW_Z  = 8'h7a;
   localparam logic [7:0] CHAR_UP_A   = 8'h41;
   localparam logic [7:0] CHAR_UP_F   = 8'h46;
   localparam logic [7:0] CHAR_UP_Z   = 8'h5a;

   // One registered input beat.
   typedef struct packed {
      logic [7:0] name_byte;
      logic       last_byte;
      logic       empty_name;
   } beat_type;

   // Character classes of one byte.
   typedef struct packed {
      logic first_ok;
      logic later_ok;
      logic is_dollar;
      logic is_dot;
      logic is_zero;
      logic is_x;
      logic is_o;
      logic is_digit;
      logic is_hex;
      logic is_oct;
   } char_class_type;

endpackage

// ===== hw/rtl/usc_char_class.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usc_char_class
// Decodes one name byte into the character classes used by the scanner.
// ----------------------------------------------------------------------------
module usc_char_class (
   input  wire logic [7:0]              name_byte,
   output usc_pkg::char_class_type      char_class
);

   logic digit;
   logic lower;
   logic upper;
   logic alnum;

   always_comb begin
      digit = (name_byte >= usc_pkg::CHAR_ZERO) && (name_byte <= usc_pkg::CHAR_NINE);
      lower = (name_byte >= usc_pkg::CHAR_LOW_A) && (name_byte <= usc_pkg::CHAR_LOW_Z);
      upper = (name_byte >= usc_pkg::CHAR_UP_A) && (name_byte <= usc_pkg::CHAR_UP_Z);
      alnum = digit || lower || upper;

      char_class.first_ok  = alnum || (name_byte == usc_pkg::CHAR_UNDER)
                             || (name_byte == usc_pkg::CHAR_DOT);
      char_class.later_ok  = char_class.first_ok || (name_byte == usc_pkg::CHAR_DASH);
      char_class.is_dollar = (name_byte == usc_pkg::CHAR_DOLLAR);
      char_class.is_dot    = (name_byte == usc_pkg::CHAR_DOT);
      char_class.is_zero   = (name_byte == usc_pkg::CHAR_ZERO);
      char_class.is_x      = (name_byte == usc_pkg::CHAR_LOW_X);
      char_class.is_o      = (name_byte == usc_pkg::CHAR_LOW_O);
      char_class.is_digit  = digit;
      char_class.is_hex    = digit
         || ((name_byte >= usc_pkg::CHAR_LOW_A) && (name_byte <= usc_pkg::CHAR_LOW_F))
         || ((name_byte >= usc_pkg::CHAR_UP_A) && (name_byte <= usc_pkg::CHAR_UP_F));
      char_class.is_oct    = (name_byte >= usc_pkg::CHAR_ZERO)
                             && (name_byte <= usc_pkg::CHAR_SEVEN);
   end

endmodule
`default_nettype wire

// ===== hw/rtl/usc_scan.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// usc_scan
// Per-name scan state: updates the flags for each beat and forms the status
// when a beat ends the name.
// ----------------------------------------------------------------------------
module usc_scan #(
   parameter int unsigned MAX_LEN = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                advance,
   input  wire usc_pkg::beat_type   beat,
   output logic [2:0]               status
);

   localparam logic [usc_pkg::COUNT_W-1:0] MaxLenC = usc_pkg::COUNT_W'(MAX_LEN);

   usc_pkg::char_class_type cls;

   logic [usc_pkg::COUNT_W-1:0] char_count_ff, char_count_in;
   logic first_is_dot_ff,  first_is_dot_in;
   logic second_is_dot_ff, second_is_dot_in;
   logic first_bad_ff,     first_bad_in;
   logic later_bad_ff,     later_bad_in;
   logic still_hex_ff,     still_hex_in;
   logic still_octal_ff,   still_octal_in;
   logic still_digits_ff,  still_digits_in;
   logic ends_name;

   usc_char_class u_char_class (
      .name_byte  (beat.name_byte),
      .char_class (cls)
   );

   always_comb begin
      first_is_dot_in  = first_is_dot_ff;
      second_is_dot_in = second_is_dot_ff;
      first_bad_in     = first_bad_ff;
      later_bad_in     = later_bad_ff;
      still_hex_in     = still_hex_ff;
      still_octal_in   = still_octal_ff;
      still_digits_in  = still_digits_ff;

      if (char_count_ff == '0) begin
         first_is_dot_in  = cls.is_dot;
         second_is_dot_in = 1'b0;
         first_bad_in     = !cls.first_ok;
         later_bad_in     = 1'b0;
         still_hex_in     = cls.is_zero;
         still_octal_in   = cls.is_zero;
         still_digits_in  = cls.is_digit;
      end else begin
         if (!(cls.later_ok || (cls.is_dollar && beat.last_byte))) begin
            later_bad_in = 1'b1;
         end
         if (char_count_ff == usc_pkg::COUNT_W'(1)) begin
            second_is_dot_in = cls.is_dot;
            still_hex_in     = still_hex_ff && cls.is_x;
            still_octal_in   = still_octal_ff && cls.is_o;
         end else begin
            still_hex_in     = still_hex_ff && cls.is_hex;
            still_octal_in   = still_octal_ff && cls.is_oct;
         end
         still_digits_in = still_digits_ff && cls.is_digit;
      end

      char_count_in = (char_count_ff < usc_pkg::COUNT_SAT)
                      ? char_count_ff + usc_pkg::COUNT_W'(1) : usc_pkg::COUNT_SAT;
   end

   // Status of a name that ends with this beat.
   always_comb begin
      priority if (beat.empty_name || (char_count_in > MaxLenC)) begin
         status = usc_pkg::STATUS_LENGTH;
      end else if (first_is_dot_in && ((char_count_in == usc_pkg::COUNT_W'(1))
                   || ((char_count_in == usc_pkg::COUNT_W'(2)) && second_is_dot_in))) begin
         status = usc_pkg::STATUS_SYNTAX;
      end else if (first_bad_in) begin
         status = usc_pkg::STATUS_FIRST;
      end else if (later_bad_in) begin
         status = usc_pkg::STATUS_SYNTAX;
      end else if (still_hex_in && (char_count_in >= usc_pkg::COUNT_W'(2))) begin
         status = usc_pkg::STATUS_HEX;
      end else if (still_octal_in && (char_count_in >= usc_pkg::COUNT_W'(2))) begin
         status = usc_pkg::STATUS_OCTAL;
      end else if (still_digits_in) begin
         status = usc_pkg::STATUS_NUMERIC;
      end else begin
         status = usc_pkg::STATUS_OK;
      end
   end

   assign ends_name = beat.last_byte || beat.empty_name;

   always_ff @(posedge clock) begin
      if (reset || (advance && ends_name)) begin
         char_count_ff    <= '0;
         first_is_dot_ff  <= 1'b0;
         second_is_dot_ff <= 1'b0;
         first_bad_ff     <= 1'b0;
         later_bad_ff     <= 1'b0;
         still_hex_ff     <= 1'b0;
         still_octal_ff   <= 1'b0;
         still_digits_ff  <= 1'b0;
      end else if (advance) begin
         char_count_ff    <= char_count_in;
         first_is_dot_ff  <= first_is_dot_in;
         second_is_dot_ff <= second_is_dot_in;
         first_bad_ff     <= first_bad_in;
         later_bad_ff     <= later_bad_in;
         still_hex_ff     <= still_hex_in;
         still_octal_ff   <= still_octal_in;
         still_digits_ff  <= still_digits_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/username_syntax_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// username_syntax_checker
// Streaming syntax check of user names, one byte per beat, one status per name.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_name_byte, req_last_byte,
//          |           |                      | req_empty_name
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_status
//
//  One byte per cycle sustained: an input register feeds the scan logic, whose
//  status lands in the output register, which raises rsp_valid once it takes
//  the status of the beat ending a name (two register stages).
//  Only the beat that ends a name waits on a full, stalled output register;
//  other bytes keep flowing. Reset (synchronous) clears the scan state and
//  empties both registers.
// ----------------------------------------------------------------------------
module username_syntax_checker #(
   parameter int unsigned MAX_LEN = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_name_byte,
   input  wire logic        req_last_byte,
   input  wire logic        req_empty_name,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status
);

   usc_pkg::beat_type beat_ff;
   logic              in_valid_ff;
   logic              rsp_valid_ff;
   logic [2:0]        rsp_status_ff;
   logic [2:0]        status;
   logic              ends_name;
   logic              out_free;
   logic              advance;

   assign ends_name = beat_ff.last_byte || beat_ff.empty_name;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!ends_name || out_free);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         beat_ff.name_byte  <= req_name_byte;
         beat_ff.last_byte  <= req_last_byte;
         beat_ff.empty_name <= req_empty_name;
      end
   end

   usc_scan #(
      .MAX_LEN (MAX_LEN)
   ) u_scan (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .beat    (beat_ff),
      .status  (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && ends_name) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && ends_name) begin
         rsp_status_ff <= status;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;

   // An empty-name beat always reports a length error.
   a_empty_is_length: assert property (@(posedge clock) disable iff (reset)
      (advance && beat_ff.empty_name) |=>
         (rsp_valid && (rsp_status == usc_pkg::STATUS_LENGTH)))
      else $error("empty name did not give a length status");

   // Never overwrite a result that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !(advance && ends_name))
      else $error("pending result overwritten");

   // A stalled input beat holds in the input register.
   a_beat_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(beat_ff)))
      else $error("stalled input beat lost");

   // A beat that does not end a name gives no new result.
   a_mid_name_quiet: assert property (@(posedge clock) disable iff (reset)
      (advance && !ends_name && !rsp_valid_ff) |=> !rsp_valid)
      else $error("result raised mid-name");

endmodule
`default_nettype wire

// ===== tb/sv/username_status_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// username_status_checker
// Watches the byte and status channels of the user name syntax checker, keeps
// its own scan of every name and compares each status beat with the oldest
// predicted status.
// ----------------------------------------------------------------------------
module username_status_checker #(
   parameter int unsigned MAX_LEN = 32
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_ready,
   input  wire logic [7:0] req_name_byte,
   input  wire logic       req_last_byte,
   input  wire logic       req_empty_name,
   input  wire logic       rsp_valid,
   input  wire logic       rsp_ready,
   input  wire logic [2:0] rsp_status,
   output int              fail_count,
   output int              expected_left
);

   logic [usc_pkg::COUNT_W-1:0] seen_count;
   logic               first_is_dot;
   logic               second_is_dot;
   logic               first_bad;
   logic               later_bad;
   logic               still_hex;
   logic               still_octal;
   logic               still_digits;

   logic [2:0]         expected_status_q[$];
   int                 mismatch_total;

   initial begin
      mismatch_total = 0;
      fail_count     = 0;
      expected_left  = 0;
   end

   function automatic logic is_digit_char(input logic [7:0] c);
      return c >= usc_pkg::CHAR_ZERO && c <= usc_pkg::CHAR_NINE;
   endfunction

   function automatic logic is_alnum_char(input logic [7:0] c);
      return is_digit_char(c) || (c >= usc_pkg::CHAR_LOW_A && c <= usc_pkg::CHAR_LOW_Z) ||
             (c >= usc_pkg::CHAR_UP_A && c <= usc_pkg::CHAR_UP_Z);
   endfunction

   function automatic logic is_hex_char(input logic [7:0] c);
      return is_digit_char(c) || (c >= usc_pkg::CHAR_LOW_A && c <= usc_pkg::CHAR_LOW_F) ||
             (c >= usc_pkg::CHAR_UP_A && c <= usc_pkg::CHAR_UP_F);
   endfunction

   task clear_scan();
      seen_count    = '0;
      first_is_dot  = 1'b0;
      second_is_dot = 1'b0;
      first_bad     = 1'b0;
      later_bad     = 1'b0;
      still_hex     = 1'b0;
      still_octal   = 1'b0;
      still_digits  = 1'b0;
   endtask

   // Advance the scan by one byte; done is set when the beat ends a name.
   task scan_name_byte(input logic [7:0] b, input logic last, input logic empty,
                       output logic done, output logic [2:0] status);
      logic char_ok;
      int   n;
      done   = 1'b0;
      status = usc_pkg::STATUS_OK;
      if (empty) begin
         clear_scan();
         done   = 1'b1;
         status = usc_pkg::STATUS_LENGTH;
         return;
      end
      if (seen_count == 0) begin
         first_is_dot  = (b == usc_pkg::CHAR_DOT);
         second_is_dot = 1'b0;
         first_bad     = !(is_alnum_char(b) || b == usc_pkg::CHAR_UNDER ||
                           b == usc_pkg::CHAR_DOT);
         later_bad     = 1'b0;
         still_hex     = (b == usc_pkg::CHAR_ZERO);
         still_octal   = (b == usc_pkg::CHAR_ZERO);
         still_digits  = is_digit_char(b);
      end else begin
         char_ok = is_alnum_char(b) || b == usc_pkg::CHAR_UNDER || b == usc_pkg::CHAR_DOT ||
                   b == usc_pkg::CHAR_DASH || (b == usc_pkg::CHAR_DOLLAR && last);
         if (!char_ok)
            later_bad = 1'b1;
         if (seen_count == 1) begin
            second_is_dot = (b == usc_pkg::CHAR_DOT);
            still_hex     = still_hex && (b == usc_pkg::CHAR_LOW_X);
            still_octal   = still_octal && (b == usc_pkg::CHAR_LOW_O);
         end else begin
            still_hex   = still_hex && is_hex_char(b);
            still_octal = still_octal && (b >= usc_pkg::CHAR_ZERO && b <= usc_pkg::CHAR_SEVEN);
         end
         still_digits = still_digits && is_digit_char(b);
      end
      if (seen_count != usc_pkg::COUNT_SAT)
         seen_count = seen_count + 1'b1;
      if (!last)
         return;

      n = int'(seen_count);
      if (n > int'(MAX_LEN))
         status = usc_pkg::STATUS_LENGTH;
      else if (first_is_dot && (n == 1 || (n == 2 && second_is_dot)))
         status = usc_pkg::STATUS_SYNTAX;
      else if (first_bad)
         status = usc_pkg::STATUS_FIRST;
      else if (later_bad)
         status = usc_pkg::STATUS_SYNTAX;
      else if (still_hex && n >= 2)
         status = usc_pkg::STATUS_HEX;
      else if (still_octal && n >= 2)
         status = usc_pkg::STATUS_OCTAL;
      else if (still_digits)
         status = usc_pkg::STATUS_NUMERIC;
      else
         status = usc_pkg::STATUS_OK;
      clear_scan();
      done = 1'b1;
   endtask

   always @(posedge clock) begin
      logic       name_done;
      logic [2:0] predicted;
      logic [2:0] oldest;
      if (reset) begin
         clear_scan();
         expected_status_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_status_q.size() == 0) begin
               if (mismatch_total < 10)
                  $display("[%0t] unexpected status beat: status=%0d", $realtime,
                           rsp_status);
               mismatch_total++;
            end else begin
               oldest = expected_status_q.pop_front();
               if (rsp_status !== oldest) begin
                  if (mismatch_total < 10)
                     $display("[%0t] status mismatch: expected=%0d actual=%0d",
                              $realtime, oldest, rsp_status);
                  mismatch_total++;
               end
            end
         end
         if (req_valid && req_ready) begin
            scan_name_byte(req_name_byte, req_last_byte, req_empty_name,
                           name_done, predicted);
            if (name_done)
               expected_status_q.push_back(predicted);
         end
      end
      fail_count    <= mismatch_total;
      expected_left <= expected_status_q.size();
   end

endmodule

// ===== tb/sv/tb_username_syntax_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_username_syntax_checker
// Streams user names into the syntax checker: a short directed set of corner
// names, then random well-formed, numeric, dotted, overlong, noisy and broken
// names, with random gaps on both channels. A status checker grades each beat.
// ----------------------------------------------------------------------------
module tb_username_syntax_checker;

   localparam int unsigned MAX_LEN     = 32;
   localparam int          ITEM_TARGET = 1300;
   localparam int          CYCLE_LIMIT = 400000;

   localparam string FIRST_SET =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_.";
   localparam string LATER_SET =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_.-";
   localparam string HEX_SET   = "0123456789abcdefABCDEF";
   localparam string OCT_SET   = "01234567";
   localparam string DIGIT_SET = "0123456789";

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_name_byte;
   logic       req_last_byte;
   logic       req_empty_name;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [2:0] rsp_status;

   int         fail_count;
   int         expected_left;
   int         cycle_count;
   int         beats_sent;
   bit         stall_on;
   logic [7:0] name_q[$];

   username_syntax_checker #(
      .MAX_LEN(MAX_LEN)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_name_byte(req_name_byte),
      .req_last_byte(req_last_byte),
      .req_empty_name(req_empty_name),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status)
   );

   username_status_checker #(
      .MAX_LEN(MAX_LEN)
   ) status_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_name_byte(req_name_byte),
      .req_last_byte(req_last_byte),
      .req_empty_name(req_empty_name),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .fail_count(fail_count),
      .expected_left(expected_left)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= stall_on ? ($urandom_range(99) >= 9) : 1'b1;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   function automatic logic [7:0] pick_from(input string set);
      return set[$urandom_range(set.len() - 1)];
   endfunction

   task automatic send_beat(input logic [7:0] b, input logic last, input logic empty);
      while (stall_on && $urandom_range(99) < 9) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_name_byte  <= b;
      req_last_byte  <= last;
      req_empty_name <= empty;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
   endtask

   // Send name_q; finish marks the final byte as the end of the name.
   task automatic send_name(input bit finish);
      for (int i = 0; i < name_q.size(); i++)
         send_beat(name_q[i], finish && (i == name_q.size() - 1), 1'b0);
   endtask

   task automatic send_text(input string s);
      name_q.delete();
      for (int i = 0; i < s.len(); i++)
         name_q.push_back(s[i]);
      send_name(1'b1);
   endtask

   // Hold off the sender until every predicted status has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_left != 0);
   endtask

   initial begin
      int pick;
      int len;
      int form;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_name_byte  = 8'h00;
      req_last_byte  = 1'b0;
      req_empty_name = 1'b0;
      rsp_ready      = 1'b0;
      stall_on       = 1'b1;
      cycle_count    = 0;
      beats_sent     = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      send_beat(8'h00, 1'b0, 1'b1);
      send_beat(8'hff, 1'b1, 1'b1);
      send_text(".");
      send_text("..");
      send_text("0");
      send_text("0x");
      send_text("0o");
      send_text("a$");
      send_text("$");
      send_text("a-");
      name_q = '{8'h00};
      send_name(1'b1);
      name_q = '{8'hff};
      send_name(1'b1);
      name_q = '{usc_pkg::CHAR_LOW_A, 8'h80};
      send_name(1'b1);
      // unfinished name cut off by an empty one
      name_q = '{usc_pkg::CHAR_LOW_A, usc_pkg::CHAR_UNDER};
      send_name(1'b0);
      send_beat(8'ha5, 1'b0, 1'b1);

      drain_results();

      while (beats_sent < ITEM_TARGET) begin
         stall_on = !(beats_sent >= 500 && beats_sent < 800);
         pick = $urandom_range(99);
         name_q.delete();
         if (pick < 40) begin
            len = $urandom_range(MAX_LEN, 1);
            name_q.push_back(pick_from(FIRST_SET));
            for (int i = 1; i < len; i++)
               name_q.push_back(pick_from(LATER_SET));
            if (len > 1 && $urandom_range(3) == 0)
               name_q[len - 1] = usc_pkg::CHAR_DOLLAR;
            send_name(1'b1);
         end else if (pick < 55) begin
            form = $urandom_range(2);
            len  = $urandom_range(10, 1);
            if (form == 2) begin
               for (int i = 0; i < len; i++)
                  name_q.push_back(pick_from(DIGIT_SET));
            end else begin
               name_q.push_back(usc_pkg::CHAR_ZERO);
               name_q.push_back(form == 0 ? usc_pkg::CHAR_LOW_X : usc_pkg::CHAR_LOW_O);
               for (int i = 0; i < len - 1; i++)
                  name_q.push_back(pick_from(form == 0 ? HEX_SET : OCT_SET));
            end
            // spoil one position now and then
            if ($urandom_range(2) == 0)
               name_q[$urandom_range(name_q.size() - 1)] = pick_from(LATER_SET);
            send_name(1'b1);
         end else if (pick < 65) begin
            name_q.push_back(usc_pkg::CHAR_DOT);
            if ($urandom_range(1) == 1)
               name_q.push_back($urandom_range(1) ? usc_pkg::CHAR_DOT
                                                  : pick_from(LATER_SET));
            if ($urandom_range(3) == 0)
               name_q.push_back(pick_from(LATER_SET));
            send_name(1'b1);
         end else if (pick < 73) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(70, 60)
                                            : $urandom_range(MAX_LEN + 2, MAX_LEN - 1);
            for (int i = 0; i < len; i++)
               name_q.push_back(pick_from(LATER_SET));
            name_q[0] = pick_from(FIRST_SET);
            send_name(1'b1);
         end else if (pick < 83) begin
            len = $urandom_range(8, 1);
            for (int i = 0; i < len; i++)
               name_q.push_back(8'($urandom_range(255)));
            send_name(1'b1);
         end else if (pick < 88) begin
            len = $urandom_range(6, 1);
            for (int i = 0; i < len; i++)
               name_q.push_back(pick_from(LATER_SET));
            name_q[$urandom_range(len - 1)] = usc_pkg::CHAR_DOLLAR;
            send_name(1'b1);
         end else if (pick < 94) begin
            send_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
         end else begin
            len = $urandom_range(5, 1);
            for (int i = 0; i < len; i++)
               name_q.push_back(pick_from(LATER_SET));
            send_name(1'b0);
            send_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
         end
      end

      drain_results();
      repeat (10) @(posedge clock);
      if (fail_count == 0 && expected_left == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
